FILE: sv/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cbz_pkg.sv
package cbz_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int NUM_POINTS = 4;
  localparam int IDX_BITS   = 2;
  localparam int NUM_AXES   = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

endpackage

FILE: sv/cubic_bezier_point_eval.sv
// channel | handshake           | payload
// in      | in_valid / in_stall | operation, point_index, point_x/y/z, t_value
// out     | out_valid/out_stall | curve_x/y/z
//
// one beat enters per cycle while in_stall is low; evaluate beats reach out_valid
// a load beat writes its control point at stage 4 and gives no output beat
// the pipeline is 8 registers: clamp, squares, cubic products, weights,
// weight-by-point multipliers, two adder levels, round and saturate
// out_stall with a held output beat freezes every stage; in_stall follows it
// rst_n clears the valid bits and the control points to zero
`include "assert_macros.svh"

module cubic_bezier_point_eval #(
  parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [cbz_pkg::IDX_BITS-1:0]     in_point_index,
  input  logic signed [COORD_BITS-1:0]     in_point_x,
  input  logic signed [COORD_BITS-1:0]     in_point_y,
  input  logic signed [COORD_BITS-1:0]     in_point_z,
  input  logic [T_FRAC_BITS:0]             in_t_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS-1:0]     out_curve_x,
  output logic signed [COORD_BITS-1:0]     out_curve_y,
  output logic signed [COORD_BITS-1:0]     out_curve_z
);
  import cbz_pkg::*;

  localparam int F  = T_FRAC_BITS;
  localparam int CW = COORD_BITS;
  localparam int TW = F + 1;
  localparam int PW = 2 * TW;
  localparam int SW = PW + 2;
  localparam int MW = TW + 1 + CW;
  localparam int AW = MW + 2;
  localparam int RW = AW + 1;
  localparam int NST = 7;

  localparam logic [TW-1:0] T_ONE = TW'(1) << F;
  localparam logic [PW-1:0] P_HALF = PW'(1) << (F - 1);
  localparam logic signed [RW-1:0] R_HALF = RW'(1) << (F - 1);

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t point_t [NUM_AXES];

  logic en;
  logic [NST-1:0] vld_r, vld_nxt;
  logic out_valid_r;

  // stage 1
  logic [TW-1:0] t1_r, u1_r, t1_nxt;
  logic op1_r;
  logic [IDX_BITS-1:0] idx1_r;
  point_t pt1_r, in_pt;
  // stage 2
  logic [TW-1:0] t2_r, u2_r, tt2_r, uu2_r;
  logic [PW-1:0] tt2_sum, uu2_sum;
  logic op2_r;
  logic [IDX_BITS-1:0] idx2_r;
  point_t pt2_r;
  // stage 3
  logic [PW-1:0] pa3_r, pb3_r, pc3_r, pd3_r;
  logic op3_r;
  logic [IDX_BITS-1:0] idx3_r;
  point_t pt3_r;
  // stage 4
  logic [TW-1:0] w4_r [NUM_POINTS];
  logic [TW-1:0] w4_nxt [NUM_POINTS];
  logic [PW-1:0] w0_sum, w3_sum;
  logic [SW-1:0] w1_sum, w2_sum;
  logic op4_r;
  logic [IDX_BITS-1:0] idx4_r;
  point_t pt4_r;
  // control points
  coord_t cp_r [NUM_POINTS][NUM_AXES];
  // stages 5 to 8
  logic signed [MW-1:0] m5_r [NUM_POINTS][NUM_AXES];
  logic signed [AW-1:0] s01_r [NUM_AXES];
  logic signed [AW-1:0] s23_r [NUM_AXES];
  logic signed [AW-1:0] acc7_r [NUM_AXES];
  logic signed [RW-1:0] rnd [NUM_AXES];
  logic signed [RW-1:0] sh [NUM_AXES];
  coord_t out_nxt [NUM_AXES];
  coord_t out_r [NUM_AXES];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign in_pt[0] = in_point_x;
  assign in_pt[1] = in_point_y;
  assign in_pt[2] = in_point_z;

  always_comb begin
    vld_nxt[0] = in_valid;
    vld_nxt[1] = vld_r[0];
    vld_nxt[2] = vld_r[1];
    vld_nxt[3] = vld_r[2];
    vld_nxt[4] = vld_r[3] && (op4_r == OP_EVAL);
    vld_nxt[5] = vld_r[4];
    vld_nxt[6] = vld_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[NST-1];
    end
  end

  // clamp t to one
  assign t1_nxt = (in_t_value > T_ONE) ? T_ONE : in_t_value;

  assign tt2_sum = PW'(t1_r) * PW'(t1_r) + P_HALF;
  assign uu2_sum = PW'(u1_r) * PW'(u1_r) + P_HALF;

  assign w0_sum = pa3_r + P_HALF;
  assign w3_sum = pd3_r + P_HALF;
  assign w1_sum = SW'(pb3_r) + (SW'(pb3_r) << 1) + SW'(P_HALF);
  assign w2_sum = SW'(pc3_r) + (SW'(pc3_r) << 1) + SW'(P_HALF);

  always_comb begin
    w4_nxt[0] = w0_sum[F +: TW];
    w4_nxt[1] = w1_sum[F +: TW];
    w4_nxt[2] = w2_sum[F +: TW];
    w4_nxt[3] = w3_sum[F +: TW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1_nxt;
      u1_r   <= T_ONE - t1_nxt;
      op1_r  <= in_operation;
      idx1_r <= in_point_index;
      pt1_r  <= in_pt;

      t2_r   <= t1_r;
      u2_r   <= u1_r;
      tt2_r  <= tt2_sum[F +: TW];
      uu2_r  <= uu2_sum[F +: TW];
      op2_r  <= op1_r;
      idx2_r <= idx1_r;
      pt2_r  <= pt1_r;

      pa3_r  <= PW'(uu2_r) * PW'(u2_r);
      pb3_r  <= PW'(t2_r) * PW'(uu2_r);
      pc3_r  <= PW'(tt2_r) * PW'(u2_r);
      pd3_r  <= PW'(tt2_r) * PW'(t2_r);
      op3_r  <= op2_r;
      idx3_r <= idx2_r;
      pt3_r  <= pt2_r;

      w4_r   <= w4_nxt;
      op4_r  <= op3_r;
      idx4_r <= idx3_r;
      pt4_r  <= pt3_r;
    end
  end

  // control points are written as a load beat leaves stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          cp_r[i][k] <= '0;
        end
      end
    end else if (en && vld_r[3] && (op4_r == OP_LOAD)) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        cp_r[idx4_r][k] <= pt4_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      rnd[k] = RW'(acc7_r[k]) + R_HALF;
      sh[k]  = rnd[k] >>> F;
      if ((&sh[k][RW-1:CW-1]) || !(|sh[k][RW-1:CW-1])) begin
        out_nxt[k] = sh[k][CW-1:0];
      end else if (sh[k][RW-1]) begin
        out_nxt[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        out_nxt[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        for (int i = 0; i < NUM_POINTS; i++) begin
          m5_r[i][k] <= MW'($signed({1'b0, w4_r[i]})) * MW'(cp_r[i][k]);
        end
        s01_r[k]  <= AW'(m5_r[0][k]) + AW'(m5_r[1][k]);
        s23_r[k]  <= AW'(m5_r[2][k]) + AW'(m5_r[3][k]);
        acc7_r[k] <= s01_r[k] + s23_r[k];
        out_r[k]  <= out_nxt[k];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_curve_x = out_r[0];
  assign out_curve_y = out_r[1];
  assign out_curve_z = out_r[2];

  `ASSERT_NEXT(a_freeze, clk, rst_n, in_stall, $stable(vld_r) && $stable(out_valid_r), "pipeline moved while frozen")
  `ASSERT_NOW(a_t_split, clk, rst_n, vld_r[0], (TW+1)'(t1_r) + (TW+1)'(u1_r) == (TW+1)'(T_ONE), "t and 1-t do not sum to one")
  `ASSERT_NEXT(a_eval_flow, clk, rst_n, vld_r[3] && (op4_r == OP_EVAL) && !in_stall, vld_r[4], "evaluate beat dropped at stage 4")
  `ASSERT_NEXT(a_load_drop, clk, rst_n, vld_r[3] && (op4_r == OP_LOAD) && !in_stall, !vld_r[4], "load beat passed stage 4")

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = cbz_pkg::COORD_BITS_DEF;
  localparam int TF = cbz_pkg::T_FRAC_BITS_DEF;
  localparam int T_ONE = 1 << TF;
  localparam int T_TOP = (2 << TF) - 1;
  localparam int BEAT_TARGET = 1750;
  localparam int LONG_HOLD = 300;
  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic                        op;
    logic [cbz_pkg::IDX_BITS-1:0] idx;
    coord_t                      x;
    coord_t                      y;
    coord_t                      z;
    logic [TF:0]                 t;
  } beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = cbz_pkg::OP_LOAD;
  logic [cbz_pkg::IDX_BITS-1:0] in_point_index = '0;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_point_z = '0;
  logic [TF:0] in_t_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_curve_x;
  coord_t out_curve_y;
  coord_t out_curve_z;

  beat_t  pending_beats [$];
  point_t points_due [$];
  longint ctrl_pts [cbz_pkg::NUM_POINTS][cbz_pkg::NUM_AXES];

  beat_t next_beat;
  bit    in_accepted = 1'b0;
  int    send_gap = 0;
  bit    tx_steady = 1'b0;
  int    stall_left = 0;
  bit    rx_steady = 1'b0;
  int    holds_done = 0;
  int    beats_in = 0;
  int    total_beats = 0;
  int    stuck_cycles = 0;
  int    errors = 0;

  cubic_bezier_point_eval #(
    .COORD_BITS (CB),
    .T_FRAC_BITS(TF)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_point_index(in_point_index),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_t_value    (in_t_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_curve_x   (out_curve_x),
    .out_curve_y   (out_curve_y),
    .out_curve_z   (out_curve_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic point_t bezier_at(logic [TF:0] t_in);
    longint one, half, hi, lo, t, u, tt, uu, acc, r;
    longint w [4];
    coord_t axis_out [3];
    point_t p;
    one  = 64'sd1 <<< TF;
    half = one >>> 1;
    hi   = (64'sd1 <<< (CB - 1)) - 1;
    lo   = -hi - 1;
    t = longint'(t_in);
    if (t > one) t = one;
    u  = one - t;
    tt = (t * t + half) >>> TF;
    uu = (u * u + half) >>> TF;
    w[0] = (uu * u + half) >>> TF;
    w[1] = (3 * t * uu + half) >>> TF;
    w[2] = (3 * tt * u + half) >>> TF;
    w[3] = (tt * t + half) >>> TF;
    for (int a = 0; a < cbz_pkg::NUM_AXES; a++) begin
      acc = 0;
      for (int i = 0; i < cbz_pkg::NUM_POINTS; i++) acc += w[i] * ctrl_pts[i][a];
      r = (acc + half) >>> TF;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      axis_out[a] = coord_t'(r);
    end
    p.x = axis_out[0];
    p.y = axis_out[1];
    p.z = axis_out[2];
    return p;
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(9, 0);
    case (r)
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return $urandom_range(1, 0) ? coord_t'(0) : coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [TF:0] rand_t();
    int r;
    r = $urandom_range(19, 0);
    case (r)
      0: return '0;
      1: return (TF+1)'(T_ONE);
      2: return (TF+1)'(1);
      3: return (TF+1)'(T_ONE - 1);
      4, 5: return (TF+1)'($urandom_range(T_TOP, T_ONE + 1));
      default: return (TF+1)'($urandom_range(T_ONE, 0));
    endcase
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 12);
  endfunction

  task automatic add_load(int idx, coord_t x, coord_t y, coord_t z);
    beat_t b;
    b.op  = cbz_pkg::OP_LOAD;
    b.idx = idx[cbz_pkg::IDX_BITS-1:0];
    b.x   = x;
    b.y   = y;
    b.z   = z;
    b.t   = (TF+1)'($urandom);
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_eval(logic [TF:0] t);
    beat_t b;
    b.op  = cbz_pkg::OP_EVAL;
    b.idx = cbz_pkg::IDX_BITS'($urandom);
    b.x   = coord_t'($urandom);
    b.y   = coord_t'($urandom);
    b.z   = coord_t'($urandom);
    b.t   = t;
    pending_beats = {pending_beats, b};
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  initial begin
    int kind, n;
    foreach (ctrl_pts[i, a]) ctrl_pts[i][a] = 0;

    // reset points, then extremes at each index
    add_eval((TF+1)'(T_ONE / 2));
    add_load(0, coord_t'(32767), coord_t'(-32768), coord_t'(0));
    add_load(1, coord_t'(-32768), coord_t'(32767), coord_t'(-1));
    add_load(2, coord_t'(32767), coord_t'(32767), coord_t'(1));
    add_load(3, coord_t'(-32768), coord_t'(-32768), coord_t'(32767));
    add_eval('0);
    add_eval((TF+1)'(T_ONE));
    add_eval((TF+1)'(T_ONE + 1));
    add_eval((TF+1)'(T_TOP));
    add_eval((TF+1)'(1));
    add_eval((TF+1)'(T_ONE - 1));
    add_eval((TF+1)'(T_ONE / 2));
    // all points at the top, then at the bottom: weight sum may saturate
    for (int i = 0; i < cbz_pkg::NUM_POINTS; i++)
      add_load(i, coord_t'(32767), coord_t'(32767), coord_t'(32767));
    add_eval((TF+1)'(T_ONE / 2));
    add_eval((TF+1)'(T_ONE / 3));
    for (int i = 0; i < cbz_pkg::NUM_POINTS; i++)
      add_load(i, coord_t'(-32768), coord_t'(-32768), coord_t'(-32768));
    add_eval((TF+1)'(T_ONE / 2));
    add_eval((TF+1)'((2 * T_ONE) / 3));

    while (pending_beats.size() < BEAT_TARGET) begin
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        if ($urandom_range(1, 0)) begin
          for (int i = 0; i < cbz_pkg::NUM_POINTS; i++)
            add_load(i, rand_coord(), rand_coord(), rand_coord());
        end else begin
          n = $urandom_range(3, 1);
          for (int i = 0; i < n; i++)
            add_load($urandom_range(3, 0), rand_coord(), rand_coord(), rand_coord());
        end
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) add_eval(rand_t());
      end else if (kind < 9) begin
        if ($urandom_range(1, 0))
          add_load($urandom_range(3, 0), rand_coord(), rand_coord(), rand_coord());
        else
          add_eval((TF+1)'($urandom));
      end else begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) add_eval((TF+1)'($urandom_range(T_TOP, 0)));
      end
    end
    total_beats = pending_beats.size();

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (beats_in == total_beats);
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        in_operation   <= next_beat.op;
        in_point_index <= next_beat.idx;
        in_point_x     <= next_beat.x;
        in_point_y     <= next_beat.y;
        in_point_z     <= next_beat.z;
        in_t_value     <= next_beat.t;
        in_valid       <= 1'b1;
        if ($urandom_range(149, 0) == 0) tx_steady = !tx_steady;
        send_gap = pick_gap(tx_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with long hold-offs once enough beats are in
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && beats_in >= 500 * (holds_done + 1)) begin
      holds_done++;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(199, 0) == 0) rx_steady = !rx_steady;
      stall_left = ($urandom_range(2, 0) == 0) ? pick_gap(rx_steady) : 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          report_mismatch($sformatf("curve point (%0d,%0d,%0d) with none due",
                                    out_curve_x, out_curve_y, out_curve_z));
        end else begin
          want = points_due.pop_front();
          if (out_curve_x !== want.x)
            report_mismatch($sformatf("curve_x got %0d want %0d", out_curve_x, want.x));
          if (out_curve_y !== want.y)
            report_mismatch($sformatf("curve_y got %0d want %0d", out_curve_y, want.y));
          if (out_curve_z !== want.z)
            report_mismatch($sformatf("curve_z got %0d want %0d", out_curve_z, want.z));
        end
      end
      if (in_valid && !in_stall) begin
        beats_in++;
        if (in_operation == cbz_pkg::OP_LOAD) begin
          ctrl_pts[in_point_index][0] = longint'(in_point_x);
          ctrl_pts[in_point_index][1] = longint'(in_point_y);
          ctrl_pts[in_point_index][2] = longint'(in_point_z);
        end else begin
          points_due = {points_due, bezier_at(in_t_value)};
        end
      end
    end
    in_accepted <= rst_n && in_valid && !in_stall;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
      stuck_cycles++;
    else
      stuck_cycles = 0;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

FILE: cubic_bezier_point_eval.f
+incdir+sv
sv/cbz_pkg.sv
sv/cubic_bezier_point_eval.sv
tb/testbench.sv
